/* hdl/mh64a_pkg.sv */
package mh64a_pkg;

  // mixing multiplier and its 32-bit halves
  localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
  localparam int unsigned MIX_SHIFT  = 47;

  // seed after reset
  localparam logic [30:0] SEED_RESET = 31'h5dee7792;

  // bytes in a full key word
  localparam logic [3:0] BYTES_PER_WORD = 4'd8;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_SEED   = 4'd2;
  localparam logic [3:0] OP_K_MIX  = 4'd3;
  localparam logic [3:0] OP_K_FOLD = 4'd4;
  localparam logic [3:0] OP_TAIL   = 4'd5;
  localparam logic [3:0] OP_H_SET  = 4'd6;
  localparam logic [3:0] OP_FIN1   = 4'd7;
  localparam logic [3:0] OP_FIN2   = 4'd8;

  // multiplier operand select
  localparam logic [1:0] MSEL_LEN  = 2'd0;
  localparam logic [1:0] MSEL_WORD = 2'd1;
  localparam logic [1:0] MSEL_K    = 2'd2;
  localparam logic [1:0] MSEL_H    = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic       mul_start;
    logic [1:0] mul_sel;
  } cmd_t;

  typedef struct packed {
    logic nbytes_full;
    logic nbytes_zero;
    logic last;
    logic mul_done;
    logic mul_busy;
    logic out_free;
  } sts_t;

endpackage

/* hdl/mh64a_mul.sv */
module mh64a_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  output logic        busy,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] a_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [1:0]  phase_r;
  logic [1:0]  phase_nxt;
  logic        run_r;
  logic        run_nxt;
  logic        done_r;
  logic        done_nxt;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pp;

  // one 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo
  assign mx = (phase_r == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign my = (phase_r == 2'd1) ? mh64a_pkg::MIX_MUL_HI : mh64a_pkg::MIX_MUL_LO;
  assign pp = mx * my;

  // accumulate registered partial products, cross terms shifted up
  always_comb begin
    acc_nxt = acc_r;
    case (phase_r)
      2'd1:    acc_nxt = prod_r;
      2'd2:    acc_nxt = acc_r + {prod_r[31:0], 32'd0};
      2'd3:    acc_nxt = acc_r + {prod_r[31:0], 32'd0};
      default: acc_nxt = acc_r;
    endcase
  end

  // sequencing
  always_comb begin
    run_nxt   = run_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    if (start) begin
      run_nxt   = 1'b1;
      phase_nxt = 2'd0;
    end else if (run_r) begin
      phase_nxt = phase_r + 2'd1;
      if (phase_r == 2'd3) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
    end
    if (run_r) begin
      prod_r <= pp;
      acc_r  <= acc_nxt;
    end
  end

  assign busy    = run_r;
  assign done    = done_r;
  assign product = acc_r;

endmodule

/* hdl/mh64a_dp.sv */
module mh64a_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mh64a_pkg::cmd_t   cmd,
  output mh64a_pkg::sts_t   sts,
  input  logic [63:0]       in_key_word,
  input  logic [3:0]        in_word_bytes,
  input  logic              in_last_word,
  input  logic [30:0]       in_key_length,
  input  logic              seed_wr,
  input  logic [30:0]       seed_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_hash_value
);

  logic [63:0] word_r;
  logic [30:0] len_r;
  logic [3:0]  nbytes_r;
  logic        last_r;
  logic [63:0] h_r;
  logic [63:0] h_nxt;
  logic [63:0] k_r;
  logic [63:0] k_nxt;
  logic [30:0] seed_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] out_hash_r;
  logic [63:0] mul_a;
  logic [63:0] mul_res;
  logic [63:0] res_sx;
  logic [63:0] h_sx;
  logic [63:0] tail_mask;
  logic        mul_busy;
  logic        mul_done;

  mh64a_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .op_a    (mul_a),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_res)
  );

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      mh64a_pkg::MSEL_LEN:  mul_a = {33'd0, len_r};
      mh64a_pkg::MSEL_WORD: mul_a = word_r;
      mh64a_pkg::MSEL_K:    mul_a = k_r;
      default:              mul_a = h_r;
    endcase
  end

  // shift-xor terms
  assign res_sx = mul_res ^ (mul_res >> mh64a_pkg::MIX_SHIFT);
  assign h_sx   = h_r ^ (h_r >> mh64a_pkg::MIX_SHIFT);

  // keep only the valid bytes of a partial word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (4'(i) < nbytes_r) ? 8'hff : 8'h00;
    end
  end

  // hash and mix registers
  always_comb begin
    h_nxt = h_r;
    k_nxt = k_r;
    case (cmd.op)
      mh64a_pkg::OP_SEED:   h_nxt = {33'd0, seed_r} ^ mul_res;
      mh64a_pkg::OP_K_MIX:  k_nxt = res_sx;
      mh64a_pkg::OP_K_FOLD: h_nxt = h_r ^ mul_res;
      mh64a_pkg::OP_TAIL:   h_nxt = h_r ^ (word_r & tail_mask);
      mh64a_pkg::OP_H_SET:  h_nxt = mul_res;
      mh64a_pkg::OP_FIN1:   h_nxt = h_sx;
      mh64a_pkg::OP_FIN2:   h_nxt = res_sx;
      default: begin
        h_nxt = h_r;
        k_nxt = k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    k_r <= k_nxt;
    if (cmd.op == mh64a_pkg::OP_LOAD) begin
      word_r   <= in_key_word;
      len_r    <= in_key_length;
      nbytes_r <= (in_word_bytes > mh64a_pkg::BYTES_PER_WORD) ?
                  mh64a_pkg::BYTES_PER_WORD : in_word_bytes;
      last_r   <= in_last_word;
    end
    if (cmd.op == mh64a_pkg::OP_FIN2) begin
      out_hash_r <= res_sx;
    end
  end

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mh64a_pkg::SEED_RESET;
    end else if (seed_wr) begin
      seed_r <= seed_data;
    end
  end

  // output register, held while stalled
  assign out_valid_nxt = (cmd.op == mh64a_pkg::OP_FIN2) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // status toward the controller
  assign sts.nbytes_full = (nbytes_r == mh64a_pkg::BYTES_PER_WORD);
  assign sts.nbytes_zero = (nbytes_r == 4'd0);
  assign sts.last        = last_r;
  assign sts.mul_done    = mul_done;
  assign sts.mul_busy    = mul_busy;
  assign sts.out_free    = !out_valid_r || !out_stall;

endmodule

/* hdl/mh64a_ctrl.sv */
module mh64a_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mh64a_pkg::sts_t   sts,
  output mh64a_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SEED_GO = 4'd1;
  localparam logic [3:0] S_SEED_W  = 4'd2;
  localparam logic [3:0] S_BODY    = 4'd3;
  localparam logic [3:0] S_K1_W    = 4'd4;
  localparam logic [3:0] S_K2_GO   = 4'd5;
  localparam logic [3:0] S_K2_W    = 4'd6;
  localparam logic [3:0] S_HMUL_GO = 4'd7;
  localparam logic [3:0] S_HMUL_W  = 4'd8;
  localparam logic [3:0] S_FIN_CHK = 4'd9;
  localparam logic [3:0] S_FIN_GO  = 4'd10;
  localparam logic [3:0] S_FIN_W   = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       inside_r;
  logic       inside_nxt;

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    inside_nxt    = inside_r;
    cmd.op        = mh64a_pkg::OP_NONE;
    cmd.mul_start = 1'b0;
    cmd.mul_sel   = mh64a_pkg::MSEL_H;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = mh64a_pkg::OP_LOAD;
          state_nxt = inside_r ? S_BODY : S_SEED_GO;
        end
      end
      S_SEED_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mh64a_pkg::MSEL_LEN;
        state_nxt     = S_SEED_W;
      end
      S_SEED_W: begin
        if (sts.mul_done) begin
          cmd.op    = mh64a_pkg::OP_SEED;
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        if (sts.nbytes_full) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mh64a_pkg::MSEL_WORD;
          state_nxt     = S_K1_W;
        end else if (!sts.nbytes_zero) begin
          cmd.op    = mh64a_pkg::OP_TAIL;
          state_nxt = S_HMUL_GO;
        end else begin
          state_nxt = S_FIN_CHK;
        end
      end
      S_K1_W: begin
        if (sts.mul_done) begin
          cmd.op    = mh64a_pkg::OP_K_MIX;
          state_nxt = S_K2_GO;
        end
      end
      S_K2_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mh64a_pkg::MSEL_K;
        state_nxt     = S_K2_W;
      end
      S_K2_W: begin
        if (sts.mul_done) begin
          cmd.op    = mh64a_pkg::OP_K_FOLD;
          state_nxt = S_HMUL_GO;
        end
      end
      S_HMUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mh64a_pkg::MSEL_H;
        state_nxt     = S_HMUL_W;
      end
      S_HMUL_W: begin
        if (sts.mul_done) begin
          cmd.op    = mh64a_pkg::OP_H_SET;
          state_nxt = S_FIN_CHK;
        end
      end
      S_FIN_CHK: begin
        if (sts.last) begin
          cmd.op    = mh64a_pkg::OP_FIN1;
          state_nxt = S_FIN_GO;
        end else begin
          inside_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FIN_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mh64a_pkg::MSEL_H;
        state_nxt     = S_FIN_W;
      end
      S_FIN_W: begin
        if (sts.mul_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op     = mh64a_pkg::OP_FIN2;
          inside_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      inside_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

/* hdl/murmur2_64a_key_hash_unit.sv */
// MurmurHash2 64A of a key streamed as little-endian 8-byte words, one word per
// transaction; the first word carries the key length and the word marked last
// returns the 64-bit hash. Words are taken one at a time, and every 64-bit
// multiply runs on a single shared 32x32 multiplier the sequencer waits on. A
// full word takes three multiplies, a partial word one and an empty word none;
// the first word of a key adds one for seeding and the last word one for
// finalizing, plus any wait for the result register to drain. The finished hash
// sits in its own output register, so the next key word is accepted while it
// waits. The seed, reset to 0x5dee7792, is written through the cfg port (always
// ready); users must write it only between keys; the block does not enforce it.
module murmur2_64a_key_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_key_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_last_word,
  input  logic [30:0] in_key_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_hash_seed
);

  mh64a_pkg::cmd_t cmd;
  mh64a_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mh64a_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mh64a_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_key_word    (in_key_word),
    .in_word_bytes  (in_word_bytes),
    .in_last_word   (in_last_word),
    .in_key_length  (in_key_length),
    .seed_wr        (cfg_valid && cfg_ready),
    .seed_data      (cfg_hash_seed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  // a multiply is never started while one is running
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiply started while busy");

  // one word at a time: after an accepted transaction input stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // the result register is loaded only when free
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mh64a_pkg::OP_FIN2) |-> sts.out_free)
    else $error("result overwritten while stalled");

  // a new result comes only from a finalize step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == mh64a_pkg::OP_FIN2))
    else $error("result valid without finalize");

endmodule
